/* hw/rtl/mlp_two_layer_tanh_inference_macros.svh */
// Assertion macros shared by the RTL of the two-layer tanh network.
// Self-contained; defining ASSERT_OFF compiles every check away.
`ifndef MLP_TWO_LAYER_TANH_INFERENCE_MACROS_SVH
`define MLP_TWO_LAYER_TANH_INFERENCE_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked at every rising edge outside reset.
`define MLP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mlp assertion failed");
// Expression that must never be true outside reset.
`define MLP_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("mlp forbidden condition seen");
`else
`define MLP_ASSERT(lbl, clk, rst, prop)
`define MLP_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

/* hw/rtl/mlptanh_pkg.sv */
// Shared sizes, state encodings and the exponent factor table of the
// two-layer tanh network. No dependencies.
`default_nettype none

package mlptanh_pkg;

  localparam int INPUT_COUNT  = 27;
  localparam int HIDDEN_COUNT = 16;
  localparam int OUTPUT_COUNT = 3;

  localparam int HO_BASE      = INPUT_COUNT * HIDDEN_COUNT;
  localparam int BH_BASE      = HO_BASE + HIDDEN_COUNT * OUTPUT_COUNT;
  localparam int BO_BASE      = BH_BASE + HIDDEN_COUNT;
  localparam int WEIGHT_TOTAL = BO_BASE + OUTPUT_COUNT;

  localparam int ADDR_W    = 9;    // weight_index field width
  localparam int VAL_W     = 16;   // Q3.12 value
  localparam int ACT_W     = 14;   // Q1.12 activation
  localparam int IDX_W     = 2;    // out_index field width
  localparam int ACC_W     = 40;   // exact Q.24 sums
  localparam int PROD_W    = 2 * VAL_W;
  localparam int FRAC_W    = 12;
  localparam int POS_W     = $clog2(INPUT_COUNT + 1);
  localparam int HCNT_W    = $clog2(HIDDEN_COUNT + 1);

  // tanh unit
  localparam int MAG_W     = 28;   // |sum| after saturation, up to 2^27
  localparam int EXP_W     = 32;   // Q.32 exponent value
  localparam int EXP_STEPS = MAG_W;
  localparam int STEP_W    = $clog2(EXP_STEPS);
  localparam int Q_W       = 13;   // quotient up to 4096
  localparam int QCNT_W    = $clog2(Q_W);
  localparam int DEN_W     = EXP_W + 3;
  localparam int REM_W     = DEN_W + Q_W - 1;

  localparam logic CMD_WEIGHT  = 1'b0;
  localparam logic CMD_FEATURE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEAT,
    ST_ACT_START,
    ST_ACT_WAIT,
    ST_OUT_MAC,
    ST_OUT_START,
    ST_OUT_WAIT,
    ST_EMIT
  } ctrl_st_t;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_MUL,
    TS_UPD,
    TS_PREP,
    TS_DIV,
    TS_DONE
  } tanh_st_t;

  // floor(exp(-2^(b-23)) * 2^32): factor for bit b of |sum| in Q.24,
  // so the product over set bits is exp(-2x).
  function automatic logic [EXP_W-1:0] exp_factor(input logic [STEP_W-1:0] b);
    logic [EXP_W-1:0] f;
    unique case (b)
      5'd0:    f = 32'd4294966784;
      5'd1:    f = 32'd4294966272;
      5'd2:    f = 32'd4294965248;
      5'd3:    f = 32'd4294963200;
      5'd4:    f = 32'd4294959104;
      5'd5:    f = 32'd4294950912;
      5'd6:    f = 32'd4294934528;
      5'd7:    f = 32'd4294901760;
      5'd8:    f = 32'd4294836226;
      5'd9:    f = 32'd4294705160;
      5'd10:   f = 32'd4294443040;
      5'd11:   f = 32'd4293918847;
      5'd12:   f = 32'd4292870655;
      5'd13:   f = 32'd4290775039;
      5'd14:   f = 32'd4286586874;
      5'd15:   f = 32'd4278222805;
      5'd16:   f = 32'd4261543595;
      5'd17:   f = 32'd4228380059;
      5'd18:   f = 32'd4162825044;
      5'd19:   f = 32'd4034748382;
      5'd20:   f = 32'd3790295335;
      5'd21:   f = 32'd3344923893;
      5'd22:   f = 32'd2605029347;
      5'd23:   f = 32'd1580030168;
      5'd24:   f = 32'd581260615;
      5'd25:   f = 32'd78665069;
      5'd26:   f = 32'd1440800;
      5'd27:   f = 32'd483;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mlp_two_layer_tanh_inference.sv */
// Two-layer perceptron, 27 Q3.12 features to 16 tanh hidden units to 3 tanh
// outputs in Q1.12. The hidden sums live in a ring of 16 cells that rotates
// past one shared multiply-add; the weights sit in a 499-entry single-write,
// dual-read store. A feature transaction holds the input while it passes
// through the 16 ring steps behind the read and multiply registers. After
// the last feature of a vector the tanh unit runs once per hidden unit
// (28 exponent steps, each a multiply and an update, and a 13-step divide),
// then each output needs 16 ring steps and one more tanh. Inputs are taken
// only while idle, never during a feature's ring pass or a vector's tanh
// and output work; the store has no reset and reads of never-written
// entries give unspecified results.
// Depends on mlptanh_pkg, mlptanh_cell, mlptanh_tanh and the macro header.
`default_nettype none
`include "mlp_two_layer_tanh_inference_macros.svh"

module mlp_two_layer_tanh_inference (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [8:0] weight_index, [24:9] value, rest zero
  input  wire logic        s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [1:0] out_index, [15:2] out_value
  output logic             m_axis_tlast
);

  localparam int NH = mlptanh_pkg::HIDDEN_COUNT;

  mlptanh_pkg::ctrl_st_t state, state_next;

  logic signed [mlptanh_pkg::VAL_W-1:0] mem [mlptanh_pkg::WEIGHT_TOTAL];

  logic [mlptanh_pkg::ADDR_W-1:0]       in_widx;
  logic signed [mlptanh_pkg::VAL_W-1:0] in_value;
  logic                                 in_acc;

  logic [mlptanh_pkg::ADDR_W-1:0]       w_addr, b_addr;
  logic signed [mlptanh_pkg::VAL_W-1:0] rdata_w, rdata_b, bias_q;
  logic signed [mlptanh_pkg::VAL_W-1:0] feat;
  logic                                 feat_first, feat_last;
  logic [mlptanh_pkg::POS_W-1:0]        pos;

  logic [mlptanh_pkg::HCNT_W-1:0]       icnt, jcnt;
  logic [mlptanh_pkg::IDX_W-1:0]        kcnt;
  logic                                 issue, v1, v2, first1, first2;
  logic                                 out_phase, mac_done, k_last;
  logic signed [mlptanh_pkg::VAL_W-1:0] mul_a;
  logic signed [mlptanh_pkg::PROD_W-1:0] prod;
  logic signed [mlptanh_pkg::ACC_W-1:0] prod_ext, bias_ext, acc_out;

  logic signed [mlptanh_pkg::ACC_W-1:0] acc [NH];
  logic signed [mlptanh_pkg::ACT_W-1:0] act [NH];
  logic                                 shift;
  logic signed [mlptanh_pkg::ACC_W-1:0] tail_acc;
  logic signed [mlptanh_pkg::ACT_W-1:0] tail_act;

  logic                                 tanh_start, tanh_done;
  logic signed [mlptanh_pkg::ACC_W-1:0] tanh_sum;
  logic signed [mlptanh_pkg::ACT_W-1:0] tanh_res;

  logic                                 m_valid;
  logic signed [mlptanh_pkg::ACT_W-1:0] out_val;
  logic                                 emit_acc;

  assign in_widx  = s_axis_tdata[mlptanh_pkg::ADDR_W-1:0];
  assign in_value = s_axis_tdata[mlptanh_pkg::ADDR_W +: mlptanh_pkg::VAL_W];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign emit_acc = m_valid && m_axis_tready;

  assign out_phase = (state == mlptanh_pkg::ST_OUT_MAC);
  assign mac_done  = (icnt == mlptanh_pkg::HCNT_W'(NH)) && !v1 && !v2;
  assign k_last    = (kcnt == mlptanh_pkg::IDX_W'(mlptanh_pkg::OUTPUT_COUNT - 1));

  assign prod_ext = {{(mlptanh_pkg::ACC_W - mlptanh_pkg::PROD_W){prod[mlptanh_pkg::PROD_W-1]}},
                     prod};
  assign bias_ext = {{(mlptanh_pkg::ACC_W - mlptanh_pkg::VAL_W - mlptanh_pkg::FRAC_W)
                      {bias_q[mlptanh_pkg::VAL_W-1]}}, bias_q, {mlptanh_pkg::FRAC_W{1'b0}}};
  assign mul_a    = out_phase
                  ? {{(mlptanh_pkg::VAL_W - mlptanh_pkg::ACT_W){act[0][mlptanh_pkg::ACT_W-1]}},
                     act[0]}
                  : feat;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mlptanh_pkg::ST_IDLE:
        if (in_acc && s_axis_tuser == mlptanh_pkg::CMD_FEATURE)
          state_next = mlptanh_pkg::ST_FEAT;
      mlptanh_pkg::ST_FEAT:
        if (mac_done)
          state_next = feat_last ? mlptanh_pkg::ST_ACT_START : mlptanh_pkg::ST_IDLE;
      mlptanh_pkg::ST_ACT_START: state_next = mlptanh_pkg::ST_ACT_WAIT;
      mlptanh_pkg::ST_ACT_WAIT:
        if (tanh_done)
          state_next = (jcnt == mlptanh_pkg::HCNT_W'(NH - 1))
                     ? mlptanh_pkg::ST_OUT_MAC : mlptanh_pkg::ST_ACT_START;
      mlptanh_pkg::ST_OUT_MAC:   if (mac_done) state_next = mlptanh_pkg::ST_OUT_START;
      mlptanh_pkg::ST_OUT_START: state_next = mlptanh_pkg::ST_OUT_WAIT;
      mlptanh_pkg::ST_OUT_WAIT:  if (tanh_done) state_next = mlptanh_pkg::ST_EMIT;
      mlptanh_pkg::ST_EMIT:
        if (emit_acc)
          state_next = k_last ? mlptanh_pkg::ST_IDLE : mlptanh_pkg::ST_OUT_MAC;
      default: state_next = mlptanh_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state == mlptanh_pkg::ST_IDLE);
    issue = (state == mlptanh_pkg::ST_FEAT || state == mlptanh_pkg::ST_OUT_MAC)
          && icnt != mlptanh_pkg::HCNT_W'(NH);
    tanh_start = (state == mlptanh_pkg::ST_ACT_START || state == mlptanh_pkg::ST_OUT_START);
    tanh_sum   = (state == mlptanh_pkg::ST_OUT_START) ? acc_out : acc[0];
    shift    = 1'b0;
    tail_acc = acc[0];
    tail_act = act[0];
    unique case (state)
      mlptanh_pkg::ST_FEAT: begin
        shift    = v2;
        // first feature of a vector: every hidden sum restarts from its bias
        tail_acc = (feat_first ? bias_ext : acc[0]) + prod_ext;
      end
      // activation leaves the head as its product is formed
      mlptanh_pkg::ST_OUT_MAC:  shift = v1;
      mlptanh_pkg::ST_ACT_WAIT: begin
        shift    = tanh_done;
        tail_act = tanh_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mlptanh_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // weight store
  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tuser == mlptanh_pkg::CMD_WEIGHT &&
        in_widx < mlptanh_pkg::ADDR_W'(mlptanh_pkg::WEIGHT_TOTAL))
      mem[in_widx] <= in_value;
  end

  always_ff @(posedge clk) begin
    rdata_w <= mem[w_addr];
    rdata_b <= mem[b_addr];
  end

  // control counters and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      icnt    <= '0;
      jcnt    <= '0;
      kcnt    <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      first1  <= 1'b0;
      first2  <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      v1     <= issue;
      first1 <= issue && icnt == '0;
      v2     <= v1;
      first2 <= first1;
      if (state != state_next) icnt <= '0;
      else if (issue)          icnt <= icnt + 1'b1;
      if (in_acc && s_axis_tuser == mlptanh_pkg::CMD_FEATURE)
        pos <= (pos == mlptanh_pkg::POS_W'(mlptanh_pkg::INPUT_COUNT - 1)) ? '0 : pos + 1'b1;
      if (state == mlptanh_pkg::ST_FEAT) jcnt <= '0;
      else if (state == mlptanh_pkg::ST_ACT_WAIT && tanh_done) jcnt <= jcnt + 1'b1;
      if (state == mlptanh_pkg::ST_ACT_WAIT) kcnt <= '0;
      else if (emit_acc && !k_last) kcnt <= kcnt + 1'b1;
      if (state == mlptanh_pkg::ST_OUT_WAIT && tanh_done) m_valid <= 1'b1;
      else if (emit_acc) m_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tuser == mlptanh_pkg::CMD_FEATURE) begin
      feat       <= in_value;
      feat_first <= (pos == '0);
      feat_last  <= (pos == mlptanh_pkg::POS_W'(mlptanh_pkg::INPUT_COUNT - 1));
      b_addr     <= mlptanh_pkg::ADDR_W'(mlptanh_pkg::BH_BASE);
      if (pos == '0) w_addr <= '0;
    end else if (issue) begin
      w_addr <= out_phase ? w_addr + mlptanh_pkg::ADDR_W'(mlptanh_pkg::OUTPUT_COUNT)
                          : w_addr + 1'b1;
      b_addr <= b_addr + 1'b1;
    end else if (state == mlptanh_pkg::ST_ACT_WAIT) begin
      w_addr <= mlptanh_pkg::ADDR_W'(mlptanh_pkg::HO_BASE);
      b_addr <= mlptanh_pkg::ADDR_W'(mlptanh_pkg::BO_BASE);
    end else if (emit_acc) begin
      w_addr <= mlptanh_pkg::ADDR_W'(mlptanh_pkg::HO_BASE) + mlptanh_pkg::ADDR_W'(kcnt) + 1'b1;
      b_addr <= mlptanh_pkg::ADDR_W'(mlptanh_pkg::BO_BASE) + mlptanh_pkg::ADDR_W'(kcnt) + 1'b1;
    end
    if (v1) begin
      prod   <= mul_a * rdata_w;
      bias_q <= rdata_b;
    end
    if (out_phase && v2)
      acc_out <= (first2 ? bias_ext : acc_out) + prod_ext;
    if (state == mlptanh_pkg::ST_OUT_WAIT && tanh_done)
      out_val <= tanh_res;
  end

  // ring of hidden cells, cell 0 at the head
  for (genvar i = 0; i < NH; i++) begin : g_ring
    if (i == NH - 1) begin : g_tail
      mlptanh_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (shift),
        .acc_in (tail_acc),
        .act_in (tail_act),
        .acc    (acc[i]),
        .act    (act[i])
      );
    end else begin : g_body
      mlptanh_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .shift  (shift),
        .acc_in (acc[i+1]),
        .act_in (act[i+1]),
        .acc    (acc[i]),
        .act    (act[i])
      );
    end
  end

  mlptanh_tanh u_tanh (
    .clk    (clk),
    .rst    (rst),
    .start  (tanh_start),
    .sum    (tanh_sum),
    .done   (tanh_done),
    .result (tanh_res)
  );

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {out_val, kcnt};
  assign m_axis_tlast  = k_last;

  `MLP_ASSERT(a_idle_no_result, clk, rst, s_axis_tready |-> !m_axis_tvalid)
  `MLP_ASSERT_NEVER(a_stray_tanh, clk, rst,
                    tanh_done && state != mlptanh_pkg::ST_ACT_WAIT &&
                    state != mlptanh_pkg::ST_OUT_WAIT)
  `MLP_ASSERT(a_emit_once, clk, rst,
              (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)

endmodule

`default_nettype wire

/* hw/rtl/mlptanh_cell.sv */
// One hidden unit of the rotating ring: holds its sum and activation and
// passes both to its neighbor on shift. Depends on mlptanh_pkg.
`default_nettype none

module mlptanh_cell (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  shift,
  input  wire logic signed [mlptanh_pkg::ACC_W-1:0]  acc_in,
  input  wire logic signed [mlptanh_pkg::ACT_W-1:0]  act_in,
  output logic signed [mlptanh_pkg::ACC_W-1:0]       acc,
  output logic signed [mlptanh_pkg::ACT_W-1:0]       act
);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      act <= '0;
    end else if (shift) begin
      acc <= acc_in;
      act <= act_in;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mlptanh_tanh.sv */
// Iterative saturating tanh: exp(-2x) as a product of table factors, a
// 32x32 multiply per magnitude bit, kept if set, then a restoring divide
// for the rounded Q1.12 result. Needs mlptanh_pkg and the assertion macro header.
`default_nettype none
`include "mlp_two_layer_tanh_inference_macros.svh"

module mlptanh_tanh (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [mlptanh_pkg::ACC_W-1:0]  sum,
  output logic                                       done,
  output logic signed [mlptanh_pkg::ACT_W-1:0]       result
);

  localparam logic signed [mlptanh_pkg::ACC_W-1:0] LIM =
    mlptanh_pkg::ACC_W'(64'sd1 <<< 27);
  localparam logic [mlptanh_pkg::EXP_W:0] ONE = {1'b1, {mlptanh_pkg::EXP_W{1'b0}}};

  mlptanh_pkg::tanh_st_t state, state_next;

  logic [mlptanh_pkg::MAG_W-1:0]    mag;
  logic                             neg;
  logic [mlptanh_pkg::STEP_W-1:0]   bcnt;
  logic [mlptanh_pkg::EXP_W-1:0]    e;
  logic [2*mlptanh_pkg::EXP_W-1:0]  prod;
  logic [mlptanh_pkg::REM_W-1:0]    rem;
  logic [mlptanh_pkg::DEN_W-1:0]    den;
  logic [mlptanh_pkg::Q_W-1:0]      q;
  logic [mlptanh_pkg::QCNT_W-1:0]   qcnt;

  logic signed [mlptanh_pkg::ACC_W-1:0] sum_abs;
  logic [mlptanh_pkg::REM_W-1:0]        trial;
  logic [mlptanh_pkg::EXP_W:0]          one_minus, one_plus;

  assign sum_abs   = sum[mlptanh_pkg::ACC_W-1] ? -sum : sum;
  assign trial     = mlptanh_pkg::REM_W'(den) << qcnt;
  assign one_minus = ONE - {1'b0, e};
  assign one_plus  = ONE + {1'b0, e};

  always_comb begin
    state_next = state;
    unique case (state)
      mlptanh_pkg::TS_IDLE: if (start) state_next = mlptanh_pkg::TS_MUL;
      mlptanh_pkg::TS_MUL:  state_next = mlptanh_pkg::TS_UPD;
      mlptanh_pkg::TS_UPD: begin
        if (bcnt == mlptanh_pkg::STEP_W'(mlptanh_pkg::EXP_STEPS - 1))
          state_next = mlptanh_pkg::TS_PREP;
        else
          state_next = mlptanh_pkg::TS_MUL;
      end
      mlptanh_pkg::TS_PREP: state_next = mlptanh_pkg::TS_DIV;
      mlptanh_pkg::TS_DIV:  if (qcnt == '0) state_next = mlptanh_pkg::TS_DONE;
      mlptanh_pkg::TS_DONE: state_next = mlptanh_pkg::TS_IDLE;
      default:              state_next = mlptanh_pkg::TS_IDLE;
    endcase
  end

  always_comb begin
    done   = (state == mlptanh_pkg::TS_DONE);
    result = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mlptanh_pkg::TS_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      mlptanh_pkg::TS_IDLE: begin
        if (start) begin
          // saturate to +-8 before taking the magnitude
          if (sum > LIM) begin
            mag <= mlptanh_pkg::MAG_W'(LIM);
            neg <= 1'b0;
          end else if (sum < -LIM) begin
            mag <= mlptanh_pkg::MAG_W'(LIM);
            neg <= 1'b1;
          end else begin
            mag <= sum_abs[mlptanh_pkg::MAG_W-1:0];
            neg <= sum[mlptanh_pkg::ACC_W-1];
          end
          bcnt <= '0;
          e    <= '1;
        end
      end
      mlptanh_pkg::TS_MUL: prod <= e * mlptanh_pkg::exp_factor(bcnt);
      mlptanh_pkg::TS_UPD: begin
        if (mag[bcnt]) e <= prod[2*mlptanh_pkg::EXP_W-1:mlptanh_pkg::EXP_W];
        bcnt <= bcnt + 1'b1;
      end
      mlptanh_pkg::TS_PREP: begin
        // round(4096*(1-e)/(1+e)) = floor((8192*(1-e) + (1+e)) / (2*(1+e)))
        rem  <= (mlptanh_pkg::REM_W'(one_minus) << 13) + mlptanh_pkg::REM_W'(one_plus);
        den  <= mlptanh_pkg::DEN_W'(one_plus) << 1;
        q    <= '0;
        qcnt <= mlptanh_pkg::QCNT_W'(mlptanh_pkg::Q_W - 1);
      end
      mlptanh_pkg::TS_DIV: begin
        if (rem >= trial) begin
          rem     <= rem - trial;
          q[qcnt] <= 1'b1;
        end
        qcnt <= qcnt - 1'b1;
      end
      mlptanh_pkg::TS_DONE: ;
      default: ;
    endcase
  end

  `MLP_ASSERT(a_done_pulse, clk, rst, done |=> !done)
  `MLP_ASSERT(a_result_range, clk, rst,
              done |-> (result <= 14'sd4096 && result >= -14'sd4096))
  `MLP_ASSERT_NEVER(a_start_busy, clk, rst,
                    start && state != mlptanh_pkg::TS_IDLE)

endmodule

`default_nettype wire
